// ----- rtl/amd_pkg.sv -----
// shared types and constants for the affine matrix decomposition pipeline
// word layouts of both channels, pipeline side-band records and stage counts
// no dependencies
package amd_pkg;

   // stage counts of the pipelined square root and divider
   localparam int SQ_STAGES  = 32;
   localparam int DIV_STAGES = 31;
   localparam int QUO_W      = 31;

   // one in Q2.30
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // input word: upper 3x3 matrix row-major plus translation row, Q16.16
   typedef struct packed {
      logic signed [31:0] r0c0;
      logic signed [31:0] r0c1;
      logic signed [31:0] r0c2;
      logic signed [31:0] r1c0;
      logic signed [31:0] r1c1;
      logic signed [31:0] r1c2;
      logic signed [31:0] r2c0;
      logic signed [31:0] r2c1;
      logic signed [31:0] r2c2;
      logic signed [31:0] trans_in_x;
      logic signed [31:0] trans_in_y;
      logic signed [31:0] trans_in_z;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        scale_x;
      logic [31:0]        scale_y;
      logic [31:0]        scale_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic               zero_scale;
   } rsp_type;

   // side-band ahead of the scale square roots
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [8:0][31:0] mag;
      logic [8:0]       neg;
   } hside_type;

   // fields that ride to the output unchanged once scales are known
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
      logic             zero;
   } base_type;

   // side-band alongside the row dividers
   typedef struct packed {
      base_type   base;
      logic [8:0] neg;
   } mside_type;

   // side-band alongside the norm square root
   typedef struct packed {
      base_type         base;
      logic             degen;
      logic [3:0]       cneg;
      logic [3:0][30:0] m;
   } tside_type;

   // side-band alongside the final dividers
   typedef struct packed {
      base_type   base;
      logic       degen;
      logic [3:0] cneg;
   } fside_type;

   // magnitude of a two's complement word, full range
   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

// ----- rtl/amd_delay.sv -----
// side-band delay line with valid bits, advanced by a common enable
// depends on amd_pkg for the default depth
module amd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = amd_pkg::DIV_STAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) data_ff[k] <= data_ff[k-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ----- rtl/amd_isqrt.sv -----
// pipelined integer square root, one result bit per stage
// depends on amd_pkg for the stage count
module amd_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [amd_pkg::SQ_STAGES];
   logic [31:0] root_ff [amd_pkg::SQ_STAGES];
   logic [63:0] rad_ff  [amd_pkg::SQ_STAGES];

   for (genvar k = 0; k < amd_pkg::SQ_STAGES; k++) begin : g_stage
      logic [33:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] rad_p;
      logic [35:0] acc;
      logic [35:0] trial;
      logic        take;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
      end

      // bring down the next bit pair and try 4r+1
      assign acc   = {rem_p, rad_p[63:62]};
      assign trial = {2'b00, root_p, 2'b01};
      assign take  = acc >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? 34'(acc - trial) : acc[33:0];
            root_ff[k] <= {root_p[30:0], take};
            rad_ff[k]  <= {rad_p[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[amd_pkg::SQ_STAGES-1];

endmodule

// ----- rtl/amd_div.sv -----
// pipelined restoring divider: floor(num * 2^30 / den), one quotient bit per stage
// needs num <= den; depends on amd_pkg for the stage count and quotient width
module amd_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [31:0]                num,
   input  logic [31:0]                den,
   output logic [amd_pkg::QUO_W-1:0]  quo
);

   logic [31:0]               rem_ff  [amd_pkg::DIV_STAGES];
   logic [31:0]               den_ff  [amd_pkg::DIV_STAGES];
   logic [amd_pkg::QUO_W-1:0] feed_ff [amd_pkg::DIV_STAGES];
   logic [amd_pkg::QUO_W-1:0] quo_ff  [amd_pkg::DIV_STAGES];

   for (genvar k = 0; k < amd_pkg::DIV_STAGES; k++) begin : g_stage
      logic [31:0]               rem_p;
      logic [31:0]               den_p;
      logic [amd_pkg::QUO_W-1:0] feed_p;
      logic [amd_pkg::QUO_W-1:0] quo_p;
      logic [32:0]               acc;
      logic                      take;

      // the upper dividend bits are num >> 1, which stays below den
      if (k == 0) begin : g_first
         assign rem_p  = {1'b0, num[31:1]};
         assign den_p  = den;
         assign feed_p = {num[0], (amd_pkg::QUO_W-1)'(0)};
         assign quo_p  = '0;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign feed_p = feed_ff[k-1];
         assign quo_p  = quo_ff[k-1];
      end

      // shift in one dividend bit and subtract if it fits
      assign acc  = {rem_p, feed_p[amd_pkg::QUO_W-1]};
      assign take = acc >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? 32'(acc - {1'b0, den_p}) : acc[31:0];
            den_ff[k]  <= den_p;
            feed_ff[k] <= {feed_p[amd_pkg::QUO_W-2:0], 1'b0};
            quo_ff[k]  <= {quo_p[amd_pkg::QUO_W-2:0], take};
         end
      end
   end

   assign quo = quo_ff[amd_pkg::DIV_STAGES-1];

endmodule

// ----- rtl/affine_matrix_decompose.sv -----
// affine matrix decomposition into translation, per-axis scale and unit quaternion
// depends on amd_pkg, amd_delay, amd_isqrt and amd_div
//
// usage
//   req channel: one 4x3 matrix word per accepted cycle (req_valid high, req_stall low),
//   elements signed Q16.16. rsp channel: one result word per matrix, in order.
//   pos is the translation row, scale the row lengths (unsigned Q16.16),
//   quat a unit quaternion in Q2.30; zero_scale flags an all-zero row and the
//   quaternion is then identity.
// pipeline and throughput
//   one matrix per cycle sustained while no result word is held under rsp_stall.
//   latency is set by two 32-stage square roots (row lengths, quaternion norm)
//   and two 31-stage dividers (row normalisation, quaternion normalisation),
//   plus a short stage chain for trace, branch select and shift normalisation.
// reset and stall
//   synchronous reset empties the pipeline; no words are in flight afterwards.
//   the whole pipeline holds while a result waits under rsp_stall, so req_stall
//   is high exactly when rsp_valid and rsp_stall are both high; nothing is lost.
module affine_matrix_decompose (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  amd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output amd_pkg::rsp_type rsp_data
);

   // quaternion branch codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   localparam int HEAD_SKEW = 2;
   localparam logic signed [34:0] ONE_C = {3'b000, amd_pkg::ONE_Q30};

   logic adv;
   logic rsp_valid_ff;
   logic q_valid;
   amd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // pipeline moves unless a finished word is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- row lengths ----------------
   logic [8:0][31:0] elem;
   assign elem = {req_data.r2c2, req_data.r2c1, req_data.r2c0,
                  req_data.r1c2, req_data.r1c1, req_data.r1c0,
                  req_data.r0c2, req_data.r0c1, req_data.r0c0};

   logic                a_valid_ff;
   amd_pkg::hside_type  a_side_ff, a_side_in;
   logic [63:0]         b_sq_ff  [9];
   logic [63:0]         c_sum_ff [3];
   logic [2:0][31:0]    scale;

   // magnitudes and signs of the incoming word
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         a_side_in.mag[k] = amd_pkg::mag32(elem[k]);
         a_side_in.neg[k] = elem[k][31];
      end
      a_side_in.pos = {req_data.trans_in_z, req_data.trans_in_y, req_data.trans_in_x};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         for (int k = 0; k < 9; k++)
            b_sq_ff[k] <= 64'(a_side_ff.mag[k]) * 64'(a_side_ff.mag[k]);
         for (int i = 0; i < 3; i++)
            c_sum_ff[i] <= b_sq_ff[3*i] + b_sq_ff[3*i+1] + b_sq_ff[3*i+2];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_scale
      amd_isqrt u_sqrt (
         .clock (clock),
         .en    (adv),
         .rad   (c_sum_ff[i]),
         .root  (scale[i])
      );
   end

   // side-band alongside the row lengths
   logic               r_valid;
   amd_pkg::hside_type r_side;

   amd_delay #(
      .WIDTH ($bits(amd_pkg::hside_type)),
      .DEPTH (HEAD_SKEW + amd_pkg::SQ_STAGES)
   ) u_head_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (a_valid_ff),
      .in_data   (a_side_ff),
      .out_valid (r_valid),
      .out_data  (r_side)
   );

   // ---------------- row normalisation ----------------
   logic [amd_pkg::QUO_W-1:0] nq [9];
   amd_pkg::mside_type        r_mside;

   always_comb begin
      r_mside.base.pos   = r_side.pos;
      r_mside.base.scale = scale;
      r_mside.base.zero  = (scale[0] == '0) || (scale[1] == '0) || (scale[2] == '0);
      r_mside.neg        = r_side.neg;
   end

   for (genvar k = 0; k < 9; k++) begin : g_rdiv
      amd_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (r_side.mag[k]),
         .den   (scale[k/3]),
         .quo   (nq[k])
      );
   end

   logic               d_valid;
   amd_pkg::mside_type d_side;

   amd_delay #(
      .WIDTH ($bits(amd_pkg::mside_type)),
      .DEPTH (amd_pkg::DIV_STAGES)
   ) u_mid_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r_valid),
      .in_data   (r_mside),
      .out_valid (d_valid),
      .out_data  (d_side)
   );

   // ---------------- quaternion direction ----------------
   logic                   e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff;
   logic                   i_valid_ff, j_valid_ff, k_valid_ff, l_valid_ff, m_valid_ff;
   logic signed [31:0]     e_n_ff [9];
   amd_pkg::base_type      e_base_ff, f_base_ff, g_base_ff, h_base_ff, i_base_ff, j_base_ff;

   logic signed [33:0]     f_t_in;
   logic [1:0]             f_br_in, f_br_ff;
   logic signed [33:0]     f_t_ff;
   logic signed [32:0]     f_d12_ff, f_d20_ff, f_d01_ff, f_s01_ff, f_s02_ff, f_s12_ff;
   logic signed [31:0]     f_n00_ff, f_n11_ff, f_n22_ff;

   logic signed [34:0]     g_c_ff [4], g_c_in [4];
   logic [33:0]            h_m_ff [4];
   logic [3:0]             h_neg_ff, i_neg_ff, j_neg_ff;
   logic [33:0]            i_mx_in, i_mx_ff, i_m_ff [4], j_m_ff [4];
   logic [5:0]             j_pos_in, j_pos_ff;
   logic                   j_degen_ff;
   logic [63:0]            k_ext [4], k_sh [4];
   amd_pkg::tside_type     k_side_in, k_side_ff, l_side_ff, m_side_ff;
   logic [61:0]            l_sq_ff [4];
   logic [63:0]            m_sum_ff;

   // signed normalised rows
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++)
            e_n_ff[k] <= d_side.neg[k] ? (32'sd0 - $signed({1'b0, nq[k]}))
                                       : $signed({1'b0, nq[k]});
         e_base_ff <= d_side.base;
      end
   end

   // trace and branch choice
   always_comb begin
      f_t_in = 34'(e_n_ff[0]) + 34'(e_n_ff[4]) + 34'(e_n_ff[8]);
      if (f_t_in > 0)
         f_br_in = BR_TRACE;
      else if ((e_n_ff[0] > e_n_ff[4]) && (e_n_ff[0] > e_n_ff[8]))
         f_br_in = BR_X;
      else if (e_n_ff[4] > e_n_ff[8])
         f_br_in = BR_Y;
      else
         f_br_in = BR_Z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_t_ff    <= f_t_in;
         f_br_ff   <= f_br_in;
         f_d12_ff  <= 33'(e_n_ff[5]) - 33'(e_n_ff[7]);
         f_d20_ff  <= 33'(e_n_ff[6]) - 33'(e_n_ff[2]);
         f_d01_ff  <= 33'(e_n_ff[1]) - 33'(e_n_ff[3]);
         f_s01_ff  <= 33'(e_n_ff[1]) + 33'(e_n_ff[3]);
         f_s02_ff  <= 33'(e_n_ff[2]) + 33'(e_n_ff[6]);
         f_s12_ff  <= 33'(e_n_ff[5]) + 33'(e_n_ff[7]);
         f_n00_ff  <= e_n_ff[0];
         f_n11_ff  <= e_n_ff[4];
         f_n22_ff  <= e_n_ff[8];
         f_base_ff <= e_base_ff;
      end
   end

   // direction components of the chosen branch
   always_comb begin
      case (f_br_ff)
         BR_TRACE: begin
            g_c_in[0] = 35'(f_t_ff) + ONE_C;
            g_c_in[1] = 35'(f_d12_ff);
            g_c_in[2] = 35'(f_d20_ff);
            g_c_in[3] = 35'(f_d01_ff);
         end
         BR_X: begin
            g_c_in[0] = 35'(f_d12_ff);
            g_c_in[1] = ONE_C + 35'(f_n00_ff) - 35'(f_n11_ff) - 35'(f_n22_ff);
            g_c_in[2] = 35'(f_s01_ff);
            g_c_in[3] = 35'(f_s02_ff);
         end
         BR_Y: begin
            g_c_in[0] = 35'(f_d20_ff);
            g_c_in[1] = 35'(f_s01_ff);
            g_c_in[2] = ONE_C + 35'(f_n11_ff) - 35'(f_n00_ff) - 35'(f_n22_ff);
            g_c_in[3] = 35'(f_s12_ff);
         end
         default: begin
            g_c_in[0] = 35'(f_d01_ff);
            g_c_in[1] = 35'(f_s02_ff);
            g_c_in[2] = 35'(f_s12_ff);
            g_c_in[3] = ONE_C + 35'(f_n22_ff) - 35'(f_n00_ff) - 35'(f_n11_ff);
         end
      endcase
   end

   // largest magnitude, then its leading one
   always_comb begin
      logic [33:0] mx01, mx23;
      mx01    = (h_m_ff[0] > h_m_ff[1]) ? h_m_ff[0] : h_m_ff[1];
      mx23    = (h_m_ff[2] > h_m_ff[3]) ? h_m_ff[2] : h_m_ff[3];
      i_mx_in = (mx01 > mx23) ? mx01 : mx23;
   end

   always_comb begin
      j_pos_in = '0;
      for (int b = 0; b < 34; b++)
         if (i_mx_ff[b]) j_pos_in = 6'(b);
   end

   // common shift that puts the largest magnitude in [2^30, 2^31)
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         k_ext[k] = {30'd0, j_m_ff[k]};
         if (j_pos_ff > 6'd30)
            k_sh[k] = k_ext[k] >> (j_pos_ff - 6'd30);
         else
            k_sh[k] = k_ext[k] << (6'd30 - j_pos_ff);
         k_side_in.m[k] = k_sh[k][30:0];
      end
      k_side_in.base  = j_base_ff;
      k_side_in.degen = j_degen_ff;
      k_side_in.cneg  = j_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            g_c_ff[k]   <= g_c_in[k];
            h_m_ff[k]   <= g_c_ff[k][34] ? 34'(-g_c_ff[k]) : 34'(g_c_ff[k]);
            h_neg_ff[k] <= g_c_ff[k][34];
            i_m_ff[k]   <= h_m_ff[k];
            j_m_ff[k]   <= i_m_ff[k];
            l_sq_ff[k]  <= 62'(k_side_ff.m[k]) * 62'(k_side_ff.m[k]);
         end
         g_base_ff  <= f_base_ff;
         h_base_ff  <= g_base_ff;
         i_mx_ff    <= i_mx_in;
         i_neg_ff   <= h_neg_ff;
         i_base_ff  <= h_base_ff;
         j_pos_ff   <= j_pos_in;
         j_degen_ff <= i_mx_ff == '0;
         j_neg_ff   <= i_neg_ff;
         j_base_ff  <= i_base_ff;
         k_side_ff  <= k_side_in;
         l_side_ff  <= k_side_ff;
         m_sum_ff   <= 64'(l_sq_ff[0]) + 64'(l_sq_ff[1]) + 64'(l_sq_ff[2])
                     + 64'(l_sq_ff[3]);
         m_side_ff  <= l_side_ff;
      end
   end

   // valid bits of the stage chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         i_valid_ff   <= 1'b0;
         j_valid_ff   <= 1'b0;
         k_valid_ff   <= 1'b0;
         l_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= req_valid;
         e_valid_ff   <= d_valid;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= f_valid_ff;
         h_valid_ff   <= g_valid_ff;
         i_valid_ff   <= h_valid_ff;
         j_valid_ff   <= i_valid_ff;
         k_valid_ff   <= j_valid_ff;
         l_valid_ff   <= k_valid_ff;
         m_valid_ff   <= l_valid_ff;
         rsp_valid_ff <= q_valid;
      end
   end

   // ---------------- quaternion normalisation ----------------
   logic [31:0]        norm;
   logic               p_valid;
   amd_pkg::tside_type p_side;
   amd_pkg::fside_type p_fside, q_side;
   logic [amd_pkg::QUO_W-1:0] qq [4];

   amd_isqrt u_norm (
      .clock (clock),
      .en    (adv),
      .rad   (m_sum_ff),
      .root  (norm)
   );

   amd_delay #(
      .WIDTH ($bits(amd_pkg::tside_type)),
      .DEPTH (amd_pkg::SQ_STAGES)
   ) u_norm_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m_valid_ff),
      .in_data   (m_side_ff),
      .out_valid (p_valid),
      .out_data  (p_side)
   );

   for (genvar k = 0; k < 4; k++) begin : g_qdiv
      amd_div u_div (
         .clock (clock),
         .en    (adv),
         .num   ({1'b0, p_side.m[k]}),
         .den   (norm),
         .quo   (qq[k])
      );
   end

   always_comb begin
      p_fside.base  = p_side.base;
      p_fside.degen = p_side.degen;
      p_fside.cneg  = p_side.cneg;
   end

   amd_delay #(
      .WIDTH ($bits(amd_pkg::fside_type)),
      .DEPTH (amd_pkg::DIV_STAGES)
   ) u_tail_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_valid),
      .in_data   (p_fside),
      .out_valid (q_valid),
      .out_data  (q_side)
   );

   // ---------------- result word ----------------
   always_comb begin
      logic signed [31:0] qv [4];
      for (int k = 0; k < 4; k++)
         qv[k] = q_side.cneg[k] ? (32'sd0 - $signed({1'b0, qq[k]}))
                                : $signed({1'b0, qq[k]});
      rsp_data_in.pos_x      = q_side.base.pos[0];
      rsp_data_in.pos_y      = q_side.base.pos[1];
      rsp_data_in.pos_z      = q_side.base.pos[2];
      rsp_data_in.scale_x    = q_side.base.scale[0];
      rsp_data_in.scale_y    = q_side.base.scale[1];
      rsp_data_in.scale_z    = q_side.base.scale[2];
      rsp_data_in.zero_scale = q_side.base.zero;
      // zero scale or an all-zero direction gives identity
      if (q_side.base.zero || q_side.degen) begin
         rsp_data_in.quat_w = amd_pkg::ONE_Q30;
         rsp_data_in.quat_x = '0;
         rsp_data_in.quat_y = '0;
         rsp_data_in.quat_z = '0;
      end else begin
         rsp_data_in.quat_w = qv[0];
         rsp_data_in.quat_x = qv[1];
         rsp_data_in.quat_y = qv[2];
         rsp_data_in.quat_z = qv[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/amd_check.sv -----
// port-level checks for affine_matrix_decompose, attached by bind
// depends on amd_pkg
module amd_check (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input amd_pkg::rsp_type rsp_data
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result word changed");

   // input is only held back by a blocked result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall without a blocked result");

   // zero-scale flag matches the scales
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.zero_scale == ((rsp_data.scale_x == '0) ||
                                            (rsp_data.scale_y == '0) ||
                                            (rsp_data.scale_z == '0)))
      else $error("zero-scale flag disagrees with scales");

   // zero scale gives the identity quaternion
   a_zero_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_scale |->
         (rsp_data.quat_w == amd_pkg::ONE_Q30) && (rsp_data.quat_x == '0) &&
         (rsp_data.quat_y == '0) && (rsp_data.quat_z == '0))
      else $error("zero scale without identity quaternion");

endmodule

bind affine_matrix_decompose amd_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
